// ----- rtl/wake_frame_receiver_unit_defines.svh -----
// Assertion macros used by the receiver top level
`ifndef WAKE_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define WAKE_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication on clk, disabled during reset
`define WFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, disabled during reset
`define WFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wfr_pkg.sv -----
// Package with the receiver's codes, result type and CRC-8 step
`timescale 1ns / 1ps
`default_nettype none

package wfr_pkg;

    localparam logic [7:0] SYM_FEND  = 8'hC0;
    localparam logic [7:0] SYM_FESC  = 8'hDB;
    localparam logic [7:0] SYM_TFEND = 8'hDC;
    localparam logic [7:0] SYM_TFESC = 8'hDD;
    localparam logic [7:0] CRC_SEED  = 8'hDE;
    localparam logic [7:0] CRC_POLY  = 8'h18;
    localparam logic [7:0] CRC_TOP   = 8'h80;
    localparam logic [7:0] ADDR_MASK = 8'h7F;
    localparam logic [6:0] OWN_ADDRESS_RESET = 7'd1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ADDR = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4
    } wfr_phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_DATA   = 2'd1,
        EV_ACCEPT = 2'd2,
        EV_ERROR  = 2'd3
    } wfr_event_t;

    typedef struct packed {
        wfr_event_t  event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [6:0]  command;
        logic [7:0]  length;
    } wfr_result_t;

    // reflected Dallas CRC-8, one byte, LSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] c;
        logic [7:0] d;
        c = crc_in;
        d = data_in;
        for (int i = 0; i < 8; i++)
        begin
            if ((c[0] ^ d[0]) == 1'b1)
            begin
                c = ((c ^ CRC_POLY) >> 1) | CRC_TOP;
            end
            else
            begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    localparam logic [7:0] CRC_AFTER_FEND = crc8_step(CRC_SEED, SYM_FEND);

endpackage

`default_nettype wire

// ----- rtl/wfr_in_if.sv -----
// Input byte channel: raw serial byte and line error flag
`timescale 1ns / 1ps
`default_nettype none

interface wfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       line_error;

    modport source (output valid, output rx_byte, output line_error, input ready);
    modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/wfr_out_if.sv -----
// Result channel: event code with payload and frame fields
`timescale 1ns / 1ps
`default_nettype none

interface wfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [6:0] command;
    logic [7:0] length;

    modport source (output valid, output event_res, output payload_byte,
                    output payload_index, output command, output length, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input payload_index, input command, input length, output ready);
endinterface

`default_nettype wire

// ----- rtl/wfr_cfg_if.sv -----
// Configuration write channel for the station address
`timescale 1ns / 1ps
`default_nettype none

interface wfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] own_address;

    modport source (output valid, output own_address, input ready);
    modport sink   (input valid, input own_address, output ready);
endinterface

`default_nettype wire

// ----- rtl/wfr_decoder.sv -----
// Frame decoder: phase, destuffing, CRC tracking and result decode
`timescale 1ns / 1ps
`default_nettype none

module wfr_decoder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                line_error,
    input  wire logic [6:0]          own_address,
    output wfr_pkg::wfr_result_t     result
);
    import wfr_pkg::*;

    wfr_phase_t phase_reg, phase_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] crc_reg, crc_next;
    logic [6:0] cmd_reg, cmd_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] pos_reg, pos_next;

    logic       is_fend;
    logic       in_frame;
    logic       esc_seq;
    logic       esc_bad;
    logic       esc_start;
    logic [7:0] dbyte;
    logic [7:0] crc_data;
    logic [7:0] crc_upd;
    logic       addr_ok;
    logic       more_data;

    assign is_fend   = (rx_byte == SYM_FEND);
    assign in_frame  = phase_reg inside {PH_ADDR, PH_CMD, PH_LEN, PH_DATA};
    assign esc_seq   = (prev_reg == SYM_FESC);
    assign esc_bad   = esc_seq && (rx_byte != SYM_TFEND) && (rx_byte != SYM_TFESC);
    assign esc_start = !esc_seq && (rx_byte == SYM_FESC);
    assign dbyte     = esc_seq ? ((rx_byte == SYM_TFESC) ? SYM_FESC : SYM_FEND) : rx_byte;

    // an address byte enters the CRC with its marker bit cleared
    assign crc_data  = ((phase_reg == PH_ADDR) && dbyte[7]) ? (dbyte & ADDR_MASK) : dbyte;
    assign crc_upd   = crc8_step(crc_reg, crc_data);
    assign addr_ok   = (dbyte[6:0] == 7'd0) || (dbyte[6:0] == own_address);
    assign more_data = (pos_reg < len_reg);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        if (step)
        begin
            if (line_error)
            begin
                phase_next = PH_IDLE;
            end
            else if (is_fend)
            begin
                prev_next  = rx_byte;
                crc_next   = CRC_AFTER_FEND;
                phase_next = PH_ADDR;
            end
            else if (in_frame)
            begin
                prev_next = rx_byte;
                if (esc_bad)
                begin
                    phase_next = PH_IDLE;
                end
                else if (!esc_start)
                begin
                    unique case (phase_reg)
                        PH_ADDR:
                        begin
                            if (dbyte[7])
                            begin
                                if (addr_ok)
                                begin
                                    crc_next   = crc_upd;
                                    phase_next = PH_CMD;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                            else
                            begin
                                // no address: this byte is the command
                                cmd_next   = dbyte[6:0];
                                crc_next   = crc_upd;
                                phase_next = PH_LEN;
                            end
                        end
                        PH_CMD:
                        begin
                            if (dbyte[7])
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                cmd_next   = dbyte[6:0];
                                crc_next   = crc_upd;
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            len_next   = dbyte;
                            crc_next   = crc_upd;
                            pos_next   = 8'd0;
                            phase_next = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            if (more_data)
                            begin
                                pos_next = pos_reg + 8'd1;
                                crc_next = crc_upd;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    // result for the byte in the decode stage
    always_comb
    begin
        result.event_res     = EV_NONE;
        result.payload_byte  = 8'd0;
        result.payload_index = 8'd0;
        result.command       = 7'd0;
        result.length        = 8'd0;
        if (line_error)
        begin
            result.event_res = EV_ERROR;
        end
        else if (!is_fend && in_frame)
        begin
            if (esc_bad)
            begin
                result.event_res = EV_ERROR;
            end
            else if (!esc_start)
            begin
                unique case (phase_reg)
                    PH_CMD:
                    begin
                        if (dbyte[7])
                        begin
                            result.event_res = EV_ERROR;
                        end
                    end
                    PH_DATA:
                    begin
                        if (more_data)
                        begin
                            result.event_res     = EV_DATA;
                            result.payload_byte  = dbyte;
                            result.payload_index = pos_reg;
                        end
                        else if (dbyte == crc_reg)
                        begin
                            result.event_res = EV_ACCEPT;
                            result.command   = cmd_reg;
                            result.length    = len_reg;
                        end
                        else
                        begin
                            result.event_res = EV_ERROR;
                        end
                    end
                    default:
                    begin
                        result.event_res = EV_NONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            prev_reg  <= 8'd0;
            crc_reg   <= 8'd0;
            cmd_reg   <= 7'd0;
            len_reg   <= 8'd0;
            pos_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            crc_reg   <= crc_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wake_frame_receiver_unit.sv -----
// Top level of the WAKE frame receiver with CRC-8 check
`timescale 1ns / 1ps
`default_nettype none
`include "wake_frame_receiver_unit_defines.svh"

// Receives one raw serial byte per transaction and returns exactly one result per byte:
// nothing, a destuffed payload byte with its index, frame accepted with command and
// length, or frame error. The block sustains one byte per clock while results are taken;
// a result is offered once its byte leaves the input register, where it sits while the
// decode, set in length by the unrolled eight-bit CRC update, runs combinationally into
// the result register. A result waiting in the output register does not stop the next
// byte from entering an empty input register; a second byte waits until the result is
// taken. The address register is written through the cfg channel, which is always
// ready; write it only while no byte is in flight. It resets to address 1.
module wake_frame_receiver_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    wfr_in_if.sink    rx,
    wfr_out_if.source res,
    wfr_cfg_if.sink   cfg
);
    import wfr_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_lerr_reg;
    logic        res_valid_reg, res_valid_next;
    wfr_result_t res_reg;
    logic [6:0]  own_address_reg;

    logic        out_free;
    logic        s1_fire;
    logic        rx_fire;
    wfr_result_t dec_result;
    logic        res_is_error;
    logic        res_fields_clear;

    assign out_free = !res_valid_reg || res.ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign rx.ready = !s1_valid_reg || out_free;
    assign rx_fire  = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    assign s1_valid_next  = rx_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign res_valid_next = s1_fire ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);

    wfr_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_fire),
        .rx_byte     (s1_byte_reg),
        .line_error  (s1_lerr_reg),
        .own_address (own_address_reg),
        .result      (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            own_address_reg <= OWN_ADDRESS_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid)
            begin
                own_address_reg <= cfg.own_address;
            end
        end
    end

    // payload: load on transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            s1_byte_reg <= rx.rx_byte;
            s1_lerr_reg <= rx.line_error;
        end
        if (s1_fire)
        begin
            res_reg <= dec_result;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.event_res     = res_reg.event_res;
    assign res.payload_byte  = res_reg.payload_byte;
    assign res.payload_index = res_reg.payload_index;
    assign res.command       = res_reg.command;
    assign res.length        = res_reg.length;

    assign res_is_error     = res_valid_reg && (res_reg.event_res == EV_ERROR);
    assign res_fields_clear = (res_reg.payload_byte == 8'd0) && (res_reg.payload_index == 8'd0)
                              && (res_reg.command == 7'd0) && (res_reg.length == 8'd0);

    `WFR_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !out_free, s1_valid_reg, "input stage lost a byte")
    `WFR_ASSERT_NEXT(a_stage_delivers, s1_fire, res_valid_reg, "decoded byte missed the result register")
    `WFR_ASSERT_NOW(a_empty_stage_ready, !s1_valid_reg, rx.ready, "empty input stage refused a byte")
    `WFR_ASSERT_NOW(a_error_clean, res_is_error, res_fields_clear, "error result carries stale fields")

endmodule

`default_nettype wire
